/* sv/b64sig_pkg.sv */
// ----------------------------------------------------------------------------
// b64sig_pkg
// Shared types, constants and the sextet lookup for the base64 signature
// checker.
// ----------------------------------------------------------------------------
package b64sig_pkg;

    // Characters of the stream that are decoded for the magic test.
    localparam int PREFIX_CHARS = 24;
    localparam int GROUP_CHARS  = (PREFIX_CHARS / 4) * 4;
    localparam int PREFIX_BYTES = (PREFIX_CHARS / 4) * 3;
    localparam int DCNT_W       = $clog2(PREFIX_BYTES + 1);

    // Only the leading bytes that a signature looks at are kept.
    localparam int MAGIC_BYTES  = 12;

    localparam int KIND_W = 3;
    localparam int MAXL_W = 26;
    localparam int CNT_W  = MAXL_W + 1;

    localparam logic [KIND_W-1:0] KIND_JPEG  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PNG   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_GIF   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WEBP  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NONE  = 3'd4;

    localparam logic [MAXL_W-1:0] MAXL_RESET = '1;

    // APB register map, one 32-bit register per word address
    localparam int PADDR_W = 3;
    localparam logic REG_IMAGE_KIND = 1'b0;
    localparam logic REG_MAX_LEN    = 1'b1;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_KIND   = 3'd1,
        ST_LONG   = 3'd2,
        ST_BAD    = 3'd3,
        ST_MAGIC  = 3'd4,
        ST_DECODE = 3'd5
    } status_t;

    typedef struct packed {
        logic [KIND_W-1:0] image_kind;
        logic [MAXL_W-1:0] max_len;
    } cfg_t;

    // Stream state after the current word, as seen by the status logic.
    typedef struct packed {
        logic [CNT_W-1:0]                  char_count;
        logic                              bad_char;
        logic                              decode_failed;
        logic [DCNT_W-1:0]                 decoded_count;
        logic [MAGIC_BYTES-1:0][7:0]       bytes;
    } stream_view_t;

    typedef struct packed {
        logic       is_pad;
        logic       is_bad;
        logic [5:0] val;
    } sextet_t;

    localparam logic [0:2][7:0] SIG_JPEG = {8'hFF, 8'hD8, 8'hFF};
    localparam logic [0:7][7:0] SIG_PNG  = {8'h89, 8'h50, 8'h4E, 8'h47,
                                            8'h0D, 8'h0A, 8'h1A, 8'h0A};
    localparam logic [0:3][7:0] SIG_GIF  = {8'h47, 8'h49, 8'h46, 8'h38};
    localparam logic [0:3][7:0] SIG_RIFF = {8'h52, 8'h49, 8'h46, 8'h46};
    localparam logic [0:3][7:0] SIG_WEBP = {8'h57, 8'h45, 8'h42, 8'h50};

    // Non-alphabet and '=' both decode as zero.
    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t s;
        s = '{is_pad: 1'b0, is_bad: 1'b0, val: 6'd0};
        if (c >= 8'h41 && c <= 8'h5A) begin
            s.val = 6'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A) begin
            s.val = 6'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39) begin
            s.val = 6'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2B) begin
            s.val = 6'd62;
        end
        else if (c == 8'h2F) begin
            s.val = 6'd63;
        end
        else if (c == 8'h3D) begin
            s.is_pad = 1'b1;
        end
        else begin
            s.is_bad = 1'b1;
        end
        return s;
    endfunction

endpackage

/* sv/base64_image_signature_validator_unit.sv */
// ----------------------------------------------------------------------------
// base64_image_signature_validator_unit
// Checks a base64 character stream against the configured image kind.
// ----------------------------------------------------------------------------
// One base64 character enters per word, at one word per clock while in_stall
// is low. Each word updates the stream state (count, alphabet flag, prefix
// decoder) in the same cycle it is taken; a word marked last_char or is_empty
// also loads a one-entry result register with the status, which appears on
// the next cycle. in_stall only rises while a finished status sits unclaimed
// in the result register and the output side stalls; otherwise the block
// takes a word every cycle.
// Software programs image_kind (reset: not allowed) and max_encoded_length
// over APB between streams. Status codes: 0 ok, 1 kind rejected, 2 too long,
// 3 bad character, 4 magic mismatch, 5 decode error; when several apply the
// order is 1, 2, 3, 5, 4. The magic and decode checks only apply to streams
// of at least 24 characters. is_empty ends a zero-length stream at once and
// drops any partial stream in progress.
module base64_image_signature_validator_unit (
    input  logic                           clk,
    input  logic                           rst_n,

    // character input
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     encoded_char,
    input  logic                           is_empty,
    input  logic                           last_char,

    // status output
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     status,

    // APB configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [b64sig_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    b64sig_pkg::cfg_t          cfg;
    b64sig_pkg::stream_view_t  view;
    b64sig_pkg::status_t       verdict;
    b64sig_pkg::status_t       status_reg, status_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      accept;
    logic                      done;

    b64sig_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // hold off input only while a status waits and output is stalled
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;
    assign done     = accept & (is_empty | last_char);

    b64sig_stream u_stream (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (accept & ~is_empty),
        .clear        (done),
        .encoded_char (encoded_char),
        .max_len      (cfg.max_len),
        .view         (view)
    );

    b64sig_judge u_judge (
        .cfg     (cfg),
        .view    (view),
        .verdict (verdict)
    );

    // empty stream: only the kind check can fail
    always_comb
    begin
        status_next    = status_reg;
        out_valid_next = out_valid_reg & out_stall;
        if (done) begin
            out_valid_next = 1'b1;
            if (is_empty) begin
                status_next = (cfg.image_kind > b64sig_pkg::KIND_WEBP) ?
                              b64sig_pkg::ST_KIND : b64sig_pkg::ST_OK;
            end
            else begin
                status_next = verdict;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;

    a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> out_valid_reg)
        else $error("stream end produced no status");

    a_kind_reject: assert property (@(posedge clk) disable iff (!rst_n)
        done && cfg.image_kind > b64sig_pkg::KIND_WEBP |=> status_reg == b64sig_pkg::ST_KIND)
        else $error("disallowed kind not reported");

endmodule

/* sv/b64sig_regs.sv */
// ----------------------------------------------------------------------------
// b64sig_regs
// APB register file: image kind and length limit.
// ----------------------------------------------------------------------------
module b64sig_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [b64sig_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output b64sig_pkg::cfg_t               cfg
);

    logic [b64sig_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [b64sig_pkg::MAXL_W-1:0] maxl_reg, maxl_next;
    logic                          wr_en;
    logic                          sel;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign sel    = paddr[2];

    always_comb
    begin
        kind_next = kind_reg;
        maxl_next = maxl_reg;
        if (wr_en) begin
            unique case (sel)
                b64sig_pkg::REG_IMAGE_KIND: kind_next = pwdata[b64sig_pkg::KIND_W-1:0];
                b64sig_pkg::REG_MAX_LEN:    maxl_next = pwdata[b64sig_pkg::MAXL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            kind_reg <= b64sig_pkg::KIND_NONE;
            maxl_reg <= b64sig_pkg::MAXL_RESET;
        end
        else begin
            kind_reg <= kind_next;
            maxl_reg <= maxl_next;
        end
    end

    always_comb
    begin
        unique case (sel)
            b64sig_pkg::REG_IMAGE_KIND: prdata = 32'(kind_reg);
            b64sig_pkg::REG_MAX_LEN:    prdata = 32'(maxl_reg);
            default:                    prdata = '0;
        endcase
    end

    assign cfg.image_kind = kind_reg;
    assign cfg.max_len    = maxl_reg;

endmodule

/* sv/b64sig_stream.sv */
// ----------------------------------------------------------------------------
// b64sig_stream
// Per-stream state: char count, alphabet check, prefix decoder.
// ----------------------------------------------------------------------------
module b64sig_stream (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              take,    // word carries a char
    input  logic                              clear,   // stream ends this cycle
    input  logic [7:0]                        encoded_char,
    input  logic [b64sig_pkg::MAXL_W-1:0]     max_len,
    output b64sig_pkg::stream_view_t          view     // state after this char
);

    logic [b64sig_pkg::CNT_W-1:0]          cnt_reg, cnt_next, cnt_upd;
    logic                                  bad_reg, bad_next, bad_upd;
    logic [23:0]                           grp_reg, grp_next, grp_upd;
    logic [b64sig_pkg::DCNT_W-1:0]         dc_reg, dc_next, dc_upd;
    logic [1:0]                            ps_reg, ps_next, ps_upd;
    logic                                  fail_reg, fail_next, fail_upd;
    logic [b64sig_pkg::MAGIC_BYTES-1:0][7:0] byte_reg, byte_next, byte_upd;

    b64sig_pkg::sextet_t                   sx;
    logic                                  in_prefix;
    logic [1:0]                            pos;
    logic [1:0]                            pads;
    logic [1:0]                            nbytes;
    logic [b64sig_pkg::DCNT_W:0]           slot;
    logic [b64sig_pkg::DCNT_W:0]           dc_sum;

    assign sx        = b64sig_pkg::sextet_of(encoded_char);
    assign in_prefix = cnt_reg < b64sig_pkg::CNT_W'(b64sig_pkg::PREFIX_CHARS);
    assign pos       = cnt_reg[1:0];

    always_comb
    begin
        bad_upd  = bad_reg | sx.is_bad;
        ps_upd   = ps_reg;
        fail_upd = fail_reg;
        grp_upd  = grp_reg;
        dc_upd   = dc_reg;
        byte_upd = byte_reg;
        pads     = 2'd0;
        nbytes   = 2'd0;
        slot     = '0;
        dc_sum   = '0;

        if (in_prefix) begin
            if (sx.is_pad) begin
                if (pos < 2'd2 || ps_reg == 2'd3) begin
                    fail_upd = 1'b1;
                end
                else if (pos == 2'd2) begin
                    ps_upd = 2'd1;
                end
                else begin
                    ps_upd = ps_reg + 2'd1;
                end
            end
            else if (ps_reg != 2'd0) begin
                fail_upd = 1'b1;
            end
            grp_upd = {grp_reg[17:0], sx.val};

            // group closes: emit 3, 2 or 1 bytes
            if (pos == 2'd3 &&
                cnt_reg < b64sig_pkg::CNT_W'(b64sig_pkg::GROUP_CHARS)) begin
                pads   = (ps_upd <= 2'd2) ? ps_upd : 2'd0;
                nbytes = 2'd3 - pads;
                for (int i = 0; i < 3; i++) begin
                    slot = (b64sig_pkg::DCNT_W+1)'(dc_reg) + (b64sig_pkg::DCNT_W+1)'(i);
                    for (int j = 0; j < b64sig_pkg::MAGIC_BYTES; j++) begin
                        if (i < int'(nbytes) && slot == (b64sig_pkg::DCNT_W+1)'(j)) begin
                            byte_upd[j] = grp_upd[16-8*i +: 8];
                        end
                    end
                end
                dc_sum = (b64sig_pkg::DCNT_W+1)'(dc_reg) + (b64sig_pkg::DCNT_W+1)'(nbytes);
                if (dc_sum > (b64sig_pkg::DCNT_W+1)'(b64sig_pkg::PREFIX_BYTES)) begin
                    dc_upd = b64sig_pkg::DCNT_W'(b64sig_pkg::PREFIX_BYTES);
                end
                else begin
                    dc_upd = dc_sum[b64sig_pkg::DCNT_W-1:0];
                end
                if (ps_upd != 2'd0) begin
                    ps_upd = 2'd3;
                end
            end
        end

        // count saturates once past the limit
        if (cnt_reg <= {1'b0, max_len}) begin
            cnt_upd = cnt_reg + 1'b1;
        end
        else begin
            cnt_upd = cnt_reg;
        end
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        bad_next  = bad_reg;
        grp_next  = grp_reg;
        dc_next   = dc_reg;
        ps_next   = ps_reg;
        fail_next = fail_reg;
        byte_next = byte_reg;
        if (clear) begin
            cnt_next  = '0;
            bad_next  = 1'b0;
            grp_next  = '0;
            dc_next   = '0;
            ps_next   = 2'd0;
            fail_next = 1'b0;
        end
        else if (take) begin
            cnt_next  = cnt_upd;
            bad_next  = bad_upd;
            grp_next  = grp_upd;
            dc_next   = dc_upd;
            ps_next   = ps_upd;
            fail_next = fail_upd;
            byte_next = byte_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            bad_reg  <= 1'b0;
            grp_reg  <= '0;
            dc_reg   <= '0;
            ps_reg   <= 2'd0;
            fail_reg <= 1'b0;
        end
        else begin
            cnt_reg  <= cnt_next;
            bad_reg  <= bad_next;
            grp_reg  <= grp_next;
            dc_reg   <= dc_next;
            ps_reg   <= ps_next;
            fail_reg <= fail_next;
        end
    end

    // decoded bytes: only entries below the decoded count are ever read
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign view.char_count    = cnt_upd;
    assign view.bad_char      = bad_upd;
    assign view.decode_failed = fail_upd;
    assign view.decoded_count = dc_upd;
    assign view.bytes         = byte_upd;

    a_dc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dc_reg <= b64sig_pkg::DCNT_W'(b64sig_pkg::PREFIX_BYTES))
        else $error("decoded count past prefix size");

    a_pad_closed: assert property (@(posedge clk) disable iff (!rst_n)
        ps_reg == 2'd3 |-> dc_reg != '0)
        else $error("padded group closed without bytes");

endmodule

/* sv/b64sig_judge.sv */
// ----------------------------------------------------------------------------
// b64sig_judge
// End-of-stream status: priority of checks and magic signature compare.
// ----------------------------------------------------------------------------
module b64sig_judge (
    input  b64sig_pkg::cfg_t          cfg,
    input  b64sig_pkg::stream_view_t  view,
    output b64sig_pkg::status_t       verdict
);

    logic jpeg_ok, png_ok, gif_ok, riff_ok, webp_ok;
    logic sig_hit;
    logic long_stream;

    always_comb
    begin
        jpeg_ok = 1'b1;
        png_ok  = 1'b1;
        gif_ok  = 1'b1;
        riff_ok = 1'b1;
        webp_ok = 1'b1;
        for (int k = 0; k < 3; k++) begin
            if (view.decoded_count <= b64sig_pkg::DCNT_W'(k) ||
                view.bytes[k] != b64sig_pkg::SIG_JPEG[k]) begin
                jpeg_ok = 1'b0;
            end
        end
        for (int k = 0; k < 8; k++) begin
            if (view.decoded_count <= b64sig_pkg::DCNT_W'(k) ||
                view.bytes[k] != b64sig_pkg::SIG_PNG[k]) begin
                png_ok = 1'b0;
            end
        end
        for (int k = 0; k < 4; k++) begin
            if (view.decoded_count <= b64sig_pkg::DCNT_W'(k) ||
                view.bytes[k] != b64sig_pkg::SIG_GIF[k]) begin
                gif_ok = 1'b0;
            end
            if (view.decoded_count <= b64sig_pkg::DCNT_W'(k) ||
                view.bytes[k] != b64sig_pkg::SIG_RIFF[k]) begin
                riff_ok = 1'b0;
            end
            // "WEBP" sits at bytes 8..11
            if (view.decoded_count <= b64sig_pkg::DCNT_W'(k + 8) ||
                view.bytes[k+8] != b64sig_pkg::SIG_WEBP[k]) begin
                webp_ok = 1'b0;
            end
        end
    end

    always_comb
    begin
        unique case (cfg.image_kind)
            b64sig_pkg::KIND_JPEG: sig_hit = jpeg_ok;
            b64sig_pkg::KIND_PNG:  sig_hit = png_ok;
            b64sig_pkg::KIND_GIF:  sig_hit = gif_ok;
            b64sig_pkg::KIND_WEBP: sig_hit = riff_ok & webp_ok;
            default:               sig_hit = 1'b0;
        endcase
    end

    assign long_stream = view.char_count >= b64sig_pkg::CNT_W'(b64sig_pkg::PREFIX_CHARS);

    always_comb
    begin
        priority if (cfg.image_kind > b64sig_pkg::KIND_WEBP) begin
            verdict = b64sig_pkg::ST_KIND;
        end
        else if (view.char_count > {1'b0, cfg.max_len}) begin
            verdict = b64sig_pkg::ST_LONG;
        end
        else if (view.bad_char) begin
            verdict = b64sig_pkg::ST_BAD;
        end
        else if (long_stream && view.decode_failed) begin
            verdict = b64sig_pkg::ST_DECODE;
        end
        else if (long_stream && (view.decoded_count < b64sig_pkg::DCNT_W'(3) || !sig_hit)) begin
            verdict = b64sig_pkg::ST_MAGIC;
        end
        else begin
            verdict = b64sig_pkg::ST_OK;
        end
    end

endmodule
